/* sv/ssme_pkg.sv */
// Shared types and codes for the sorted set merge engine.
`default_nettype none
package ssme_pkg;

   // request codes
   localparam logic [3:0] REQ_CLEAR_A   = 4'd0;
   localparam logic [3:0] REQ_APPEND_A  = 4'd1;
   localparam logic [3:0] REQ_CLEAR_B   = 4'd2;
   localparam logic [3:0] REQ_APPEND_B  = 4'd3;
   localparam logic [3:0] REQ_UNION     = 4'd4;
   localparam logic [3:0] REQ_INTERSECT = 4'd5;
   localparam logic [3:0] REQ_DIFF      = 4'd6;
   localparam logic [3:0] REQ_MEMBER    = 4'd7;
   localparam logic [3:0] REQ_SUBSET    = 4'd8;
   localparam logic [3:0] REQ_EQUAL     = 4'd9;
   localparam logic [3:0] REQ_STRICT    = 4'd10;
   localparam logic [3:0] REQ_READ_A    = 4'd11;

   // result status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_FULL     = 2'd1;
   localparam logic [1:0] STAT_NOT_ASC  = 2'd2;
   localparam logic [1:0] STAT_RANGE    = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EXEC,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_DONE
   } ssme_state_type;

   typedef struct packed {
      logic load;
      logic fetch;
      logic exec;
      logic copy_rd;
      logic copy_wr;
      logic publish;
   } ssme_cmd_type;

   typedef struct packed {
      logic done;
      logic copy;
      logic copy_last;
   } ssme_status_type;

endpackage
`default_nettype wire

/* sv/ssme_ctrl.sv */
// Controller state machine of the sorted set merge engine.
`default_nettype none
module ssme_ctrl
   import ssme_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   input  wire ssme_status_type st,
   output ssme_cmd_type         cmd
);

   ssme_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_FETCH;
         end
         ST_FETCH: state_in = ST_EXEC;
         ST_EXEC: begin
            if (st.done) state_in = st.copy ? ST_COPY_RD : ST_DONE;
            else         state_in = ST_FETCH;
         end
         ST_COPY_RD: state_in = ST_COPY_WR;
         ST_COPY_WR: begin
            if (st.copy_last) state_in = ST_DONE;
            else              state_in = ST_COPY_RD;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:    cmd.load    = req_valid;
         ST_FETCH:   cmd.fetch   = 1'b1;
         ST_EXEC:    cmd.exec    = 1'b1;
         ST_COPY_RD: cmd.copy_rd = 1'b1;
         ST_COPY_WR: cmd.copy_wr = 1'b1;
         ST_DONE:    cmd.publish = out_free;
         default:    cmd = '0;
      endcase
   end

   assign rsp_valid_in = cmd.publish || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> !(rsp_valid_ff && rsp_stall))
      else $error("result published over a stalled item");
   a_accept_fetch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_FETCH))
      else $error("accepted item did not start a fetch");
   a_copy_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && st.copy) |-> st.done)
      else $error("copy requested before merge finished");

endmodule
`default_nettype wire

/* sv/ssme_datapath.sv */
// Datapath of the sorted set merge engine: set stores, walk pointers, result registers.
`default_nettype none
module ssme_datapath
   import ssme_pkg::*;
#(
   parameter int CAPACITY = 1024
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ssme_cmd_type        cmd,
   output ssme_status_type          st,
   input  wire logic [3:0]          req_type,
   input  wire logic signed [31:0]  req_value,
   input  wire logic [9:0]          req_index,
   output logic [1:0]               rsp_status,
   output logic                     rsp_answer,
   output logic signed [31:0]       rsp_read_value,
   output logic [10:0]              rsp_size_a
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam logic [CW-1:0] CAP = CW'(CAPACITY);

   logic [31:0] mem_a [CAPACITY];
   logic [31:0] mem_b [CAPACITY];
   logic [31:0] mem_s [CAPACITY];

   logic [3:0]         op_ff;
   logic signed [31:0] val_ff;
   logic [9:0]         idx_ff;
   logic [CW-1:0]      count_a_ff, count_a_in;
   logic [CW-1:0]      count_b_ff, count_b_in;
   logic [CW-1:0]      i_ff, i_in, j_ff, j_in, n_ff, n_in;
   logic [1:0]         res_status_ff, res_status_in;
   logic               res_answer_ff, res_answer_in;
   logic signed [31:0] res_rd_ff, res_rd_in;
   logic signed [31:0] a_q, b_q, s_q;
   logic [1:0]         out_status_ff;
   logic               out_answer_ff;
   logic signed [31:0] out_rd_ff;
   logic [10:0]        out_size_ff;

   logic [CW-1:0]      addr_a, addr_b;
   logic               wr_a, wr_b, wr_s;
   logic [CW-1:0]      wa_addr, ws_addr;
   logic [31:0]        wa_data, ws_data;
   logic               a_avail, b_avail, take_a, take_b, emit;
   logic signed [31:0] pick;

   // read addresses
   always_comb begin
      unique case (op_ff)
         REQ_APPEND_A: addr_a = count_a_ff - 1'b1;
         REQ_READ_A:   addr_a = CW'(idx_ff);
         default:      addr_a = i_ff;
      endcase
      addr_b = (op_ff == REQ_APPEND_B) ? (count_b_ff - 1'b1) : j_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         a_q <= mem_a[addr_a[AW-1:0]];
         b_q <= mem_b[addr_b[AW-1:0]];
      end
      if (cmd.copy_rd) s_q <= mem_s[i_ff[AW-1:0]];
      if (wr_a) mem_a[wa_addr[AW-1:0]] <= wa_data;
      if (wr_b) mem_b[count_b_ff[AW-1:0]] <= val_ff;
      if (wr_s) mem_s[ws_addr[AW-1:0]] <= ws_data;
   end

   assign a_avail = (i_ff < count_a_ff);
   assign b_avail = (j_ff < count_b_ff);

   always_comb begin
      take_a = 1'b0;
      take_b = 1'b0;
      emit   = 1'b0;
      pick   = a_q;
      priority if (!b_avail || (a_avail && a_q < b_q)) begin
         take_a = 1'b1;
         emit   = (op_ff != REQ_INTERSECT);
      end else if (!a_avail || b_q < a_q) begin
         take_b = 1'b1;
         pick   = b_q;
         emit   = (op_ff == REQ_UNION);
      end else begin
         take_a = 1'b1;
         take_b = 1'b1;
         emit   = (op_ff != REQ_DIFF);
      end
   end

   always_comb begin
      count_a_in    = count_a_ff;
      count_b_in    = count_b_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      n_in          = n_ff;
      res_status_in = res_status_ff;
      res_answer_in = res_answer_ff;
      res_rd_in     = res_rd_ff;
      wr_a          = 1'b0;
      wr_b          = 1'b0;
      wr_s          = 1'b0;
      wa_addr       = count_a_ff;
      wa_data       = val_ff;
      ws_addr       = n_ff;
      ws_data       = pick;
      st            = '0;
      if (cmd.load) begin
         i_in          = '0;
         j_in          = '0;
         n_in          = '0;
         res_status_in = STAT_OK;
         res_answer_in = 1'b0;
         res_rd_in     = '0;
      end else if (cmd.exec) begin
         st.done = 1'b1;
         unique case (op_ff)
            REQ_CLEAR_A: count_a_in = '0;
            REQ_CLEAR_B: count_b_in = '0;
            REQ_APPEND_A: begin
               priority if (count_a_ff >= CAP) res_status_in = STAT_FULL;
               else if (count_a_ff != '0 && val_ff <= a_q) res_status_in = STAT_NOT_ASC;
               else begin
                  wr_a       = 1'b1;
                  count_a_in = count_a_ff + 1'b1;
               end
            end
            REQ_APPEND_B: begin
               priority if (count_b_ff >= CAP) res_status_in = STAT_FULL;
               else if (count_b_ff != '0 && val_ff <= b_q) res_status_in = STAT_NOT_ASC;
               else begin
                  wr_b       = 1'b1;
                  count_b_in = count_b_ff + 1'b1;
               end
            end
            REQ_UNION, REQ_INTERSECT, REQ_DIFF: begin
               if (!a_avail && !b_avail) begin
                  // walk finished: copy scratch back unless empty
                  if (n_ff == '0) count_a_in = '0;
                  else begin
                     st.copy = 1'b1;
                     i_in    = '0;
                  end
               end else if (emit && n_ff >= CAP) begin
                  res_status_in = STAT_FULL;
               end else begin
                  st.done = 1'b0;
                  if (emit) begin
                     wr_s = 1'b1;
                     n_in = n_ff + 1'b1;
                  end
                  if (take_a) i_in = i_ff + 1'b1;
                  if (take_b) j_in = j_ff + 1'b1;
               end
            end
            REQ_MEMBER: begin
               if (a_avail) begin
                  if (a_q == val_ff) res_answer_in = 1'b1;
                  else begin
                     st.done = 1'b0;
                     i_in    = i_ff + 1'b1;
                  end
               end
            end
            REQ_SUBSET, REQ_EQUAL, REQ_STRICT: begin
               // equal is subset with equal sizes; strict is subset with unequal sizes
               priority if (op_ff == REQ_EQUAL && count_a_ff != count_b_ff) begin
                  res_answer_in = 1'b0;
               end else if (!a_avail) begin
                  res_answer_in = (op_ff == REQ_STRICT) ? (count_a_ff != count_b_ff) : 1'b1;
               end else if (!b_avail || a_q < b_q) begin
                  res_answer_in = 1'b0;
               end else begin
                  st.done = 1'b0;
                  if (a_q == b_q) i_in = i_ff + 1'b1;
                  j_in = j_ff + 1'b1;
               end
            end
            REQ_READ_A: begin
               if (32'(idx_ff) < 32'(count_a_ff)) res_rd_in = a_q;
               else res_status_in = STAT_RANGE;
            end
            default: st.done = 1'b1;
         endcase
      end else if (cmd.copy_wr) begin
         wr_a         = 1'b1;
         wa_addr      = i_ff;
         wa_data      = s_q;
         i_in         = i_ff + 1'b1;
         st.copy_last = (i_in == n_ff);
         if (st.copy_last) count_a_in = n_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff <= '0;
         count_b_ff <= '0;
      end else begin
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_type;
         val_ff <= req_value;
         idx_ff <= req_index;
      end
      i_ff          <= i_in;
      j_ff          <= j_in;
      n_ff          <= n_in;
      res_status_ff <= res_status_in;
      res_answer_ff <= res_answer_in;
      res_rd_ff     <= res_rd_in;
      if (cmd.publish) begin
         out_status_ff <= res_status_ff;
         out_answer_ff <= res_answer_ff;
         out_rd_ff     <= res_rd_ff;
         out_size_ff   <= 11'(count_a_ff);
      end
   end

   assign rsp_status     = out_status_ff;
   assign rsp_answer     = out_answer_ff;
   assign rsp_read_value = out_rd_ff;
   assign rsp_size_a     = out_size_ff;

   a_count_a_cap: assert property (@(posedge clock) disable iff (reset)
      count_a_ff <= CAP)
      else $error("count of A above capacity");
   a_count_b_cap: assert property (@(posedge clock) disable iff (reset)
      count_b_ff <= CAP)
      else $error("count of B above capacity");
   a_scratch_write: assert property (@(posedge clock) disable iff (reset)
      wr_s |-> (n_ff < CAP))
      else $error("scratch write past capacity");

endmodule
`default_nettype wire

/* sv/sorted_set_merge_engine_unit.sv */
// Top level of the sorted set merge engine.
//
//  channel | direction | handshake           | payload
//  req_    | in        | req_valid/req_stall | req_type, req_value, req_index
//  rsp_    | out       | rsp_valid/rsp_stall | rsp_status, rsp_answer, rsp_read_value, rsp_size_a
//
// One item at a time. Clears, appends, reads and unused codes pass once through the fetch,
// execute and done states; the result enters the output register in the done state once
// that register is free, and the next item is taken back in idle. Member and subset/equal/strict
// walks repeat fetch and execute for each element visited; merges repeat them per step of the
// walk and to close it, then copy-read and copy-write per element copied back to A.
// Reset clears both counts; store contents are undefined until written.
// A stalled result sits in the output register while the next item is taken.
`default_nettype none
module sorted_set_merge_engine_unit
   import ssme_pkg::*;
#(
   parameter int CAPACITY = 1024
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [3:0]         req_type,
   input  wire logic signed [31:0] req_value,
   input  wire logic [9:0]         req_index,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic                    rsp_answer,
   output logic signed [31:0]      rsp_read_value,
   output logic [10:0]             rsp_size_a
);

   ssme_cmd_type    cmd;
   ssme_status_type st;

   ssme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .st        (st),
      .cmd       (cmd)
   );

   ssme_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .st             (st),
      .req_type       (req_type),
      .req_value      (req_value),
      .req_index      (req_index),
      .rsp_status     (rsp_status),
      .rsp_answer     (rsp_answer),
      .rsp_read_value (rsp_read_value),
      .rsp_size_a     (rsp_size_a)
   );

endmodule
`default_nettype wire
